### rtl/core/assert_macros.svh
// Assertion shorthands for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define RCBA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RCBA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/rcba_pkg.sv
package rcba_pkg;

   localparam int BLOCK_W = 16;
   localparam int COUNT_W = 8;
   localparam int TOTAL_W = 17;

   // Bytes per block. The map size is a ceiling divide by this value, done as a shift,
   // so it must stay a power of two.
   localparam int BLOCK_BYTES = 4096;
   localparam int BB_SHIFT = $clog2(BLOCK_BYTES);

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(65536);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Largest block number that the result field can carry, plus one.
   localparam int ALLOC_LIMIT = 1 << BLOCK_W;

   typedef enum logic [2:0] {
      MODE_ALLOC = 3'd0,
      MODE_INC   = 3'd1,
      MODE_DEC   = 3'd2,
      MODE_QUERY = 3'd3,
      MODE_INIT  = 3'd4
   } mode_type;

endpackage

### rtl/core/refcount_block_allocator.sv
// Reference-counted first-fit block allocator. Each block of the store has an 8-bit count
// held in one single-port-read, single-port-write memory of MAX_BLOCKS entries with a
// registered read. After reset the block runs a clearing pass over all MAX_BLOCKS entries
// and holds req_stall high until it is done. Every write to csr_wr_data starts a
// recount pass, because the free count depends on the total; req_stall stays high until
// the recount pass is done. Query, increment and decrement read, modify and write one
// entry and deliver their result through the states S_READ, S_MOD and S_OUT. Init
// rewrites every entry in a clearing pass before it delivers its result. Allocate scans
// the memory one entry per cycle from a low-water mark below which no data block is free
// and stops at the first free entry or at the end of the allocatable range. One request
// is in flight at a time; a finished result may wait in the output register while the
// next request beat is accepted.
module refcount_block_allocator #(
   parameter int MAX_BLOCKS = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_mode,
   input  logic [rcba_pkg::BLOCK_W-1:0]        req_block_number,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rcba_pkg::BLOCK_W-1:0]        rsp_result_block,
   output logic [rcba_pkg::COUNT_W-1:0]        rsp_ref_count,
   output logic [rcba_pkg::TOTAL_W-1:0]        rsp_free_count,
   output logic [rcba_pkg::TOTAL_W-1:0]        rsp_total_count,
   input  logic                                csr_wr_en,
   input  logic [rcba_pkg::TOTAL_W-1:0]        csr_wr_data
);
   import rcba_pkg::*;

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int SW = AW + 1;
   // Wide enough for block numbers, the total and the first data block.
   localparam int CW = (AW + 1 > TOTAL_W + 1) ? AW + 1 : TOTAL_W + 1;
   localparam logic [SW-1:0] SWEEP_END = SW'(MAX_BLOCKS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BLOCKS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_COUNT,
      S_IDLE,
      S_READ,
      S_MOD,
      S_SCAN,
      S_OUT
   } state_type;

   logic [COUNT_W-1:0] count_mem [MAX_BLOCKS];
   logic [COUNT_W-1:0] rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [COUNT_W-1:0] mem_wdata;
   logic [AW-1:0]      mem_raddr;

   state_type          state_ff, state_in;
   logic [2:0]         mode_ff, mode_in;
   logic [BLOCK_W-1:0] blk_ff, blk_in;
   logic [SW-1:0]      sweep_ff, sweep_in;
   logic               init_clr_ff, init_clr_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic               chk_v_ff, chk_v_in;
   logic [CW-1:0]      chk_addr_ff, chk_addr_in;
   logic [CW-1:0]      hint_ff, hint_in;
   logic [TOTAL_W-1:0] free_ff, free_in;
   logic               dirty_ff, dirty_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [BLOCK_W-1:0] res_block_ff, res_block_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0] rsp_block_ff, rsp_block_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [TOTAL_W-1:0] rsp_free_ff, rsp_free_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic [CW-1:0]      total_ext;
   logic [CW-1:0]      eff_total;
   logic [CW-1:0]      data_base;
   logic [CW-1:0]      alloc_end;
   logic [CW-1:0]      blk_ext;
   logic [CW-1:0]      free_span;
   logic [TOTAL_W-1:0] free_init;
   logic               in_total;
   logic               is_data;
   logic               chk_in_range;
   logic [COUNT_W-1:0] new_count;
   logic               accept;

   // Bounds that follow from the configured total.
   assign total_ext  = CW'(total_ff);
   assign eff_total  = (total_ext < CW'(MAX_BLOCKS)) ? total_ext : CW'(MAX_BLOCKS);
   assign data_base  = CW'(1) + ((total_ext + CW'(BLOCK_BYTES - 1)) >> BB_SHIFT);
   assign alloc_end  = (eff_total > CW'(ALLOC_LIMIT)) ? CW'(ALLOC_LIMIT) : eff_total;
   assign free_span  = eff_total - data_base;
   assign free_init  = (eff_total > data_base) ? free_span[TOTAL_W-1:0] : '0;

   assign blk_ext      = CW'(blk_ff);
   assign in_total     = blk_ext < eff_total;
   assign is_data      = in_total && (blk_ext >= data_base);
   assign chk_in_range = (chk_addr_ff >= data_base) && (chk_addr_ff < eff_total);

   assign req_stall = !((state_ff == S_IDLE) && !dirty_ff);
   assign accept    = req_valid && !req_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_block_ff;
   assign rsp_ref_count    = rsp_count_ff;
   assign rsp_free_count   = rsp_free_ff;
   assign rsp_total_count  = rsp_total_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      blk_in       = blk_ff;
      sweep_in     = sweep_ff;
      init_clr_in  = init_clr_ff;
      scan_in      = scan_ff;
      chk_v_in     = 1'b0;
      chk_addr_in  = chk_addr_ff;
      hint_in      = hint_ff;
      free_in      = free_ff;
      dirty_in     = dirty_ff;
      res_block_in = res_block_ff;
      res_count_in = res_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_block_in = rsp_block_ff;
      rsp_count_in = rsp_count_ff;
      rsp_free_in  = rsp_free_ff;
      rsp_total_in = rsp_total_ff;
      mem_we       = 1'b0;
      mem_waddr    = sweep_ff[AW-1:0];
      mem_wdata    = '0;
      mem_raddr    = sweep_ff[AW-1:0];
      new_count    = rd_data_ff;

      case (state_ff)
         S_CLEAR: begin
            // Init leaves block 0 and the map blocks reserved; reset leaves all at zero.
            mem_we    = 1'b1;
            mem_wdata = (init_clr_ff && (CW'(sweep_ff) < data_base)
                         && (CW'(sweep_ff) < eff_total)) ? COUNT_W'(1) : '0;
            sweep_in  = sweep_ff + SW'(1);
            if (sweep_ff[AW-1:0] == LAST_ADDR) begin
               free_in = free_init;
               hint_in = data_base;
               if (init_clr_ff) begin
                  res_block_in = '0;
                  res_count_in = '0;
                  state_in     = S_OUT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_COUNT: begin
            if (chk_v_ff && (rd_data_ff == '0) && chk_in_range) begin
               free_in = free_ff + TOTAL_W'(1);
            end
            if (sweep_ff != SWEEP_END) begin
               mem_raddr   = sweep_ff[AW-1:0];
               chk_v_in    = 1'b1;
               chk_addr_in = CW'(sweep_ff);
               sweep_in    = sweep_ff + SW'(1);
            end else if (!chk_v_ff) begin
               hint_in  = data_base;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (dirty_ff) begin
               dirty_in = 1'b0;
               sweep_in = '0;
               free_in  = '0;
               state_in = S_COUNT;
            end else if (accept) begin
               mode_in = req_mode;
               blk_in  = req_block_number;
               case (req_mode)
                  MODE_ALLOC: begin
                     scan_in  = hint_ff;
                     state_in = S_SCAN;
                  end
                  MODE_INC, MODE_DEC, MODE_QUERY: begin
                     state_in = S_READ;
                  end
                  MODE_INIT: begin
                     init_clr_in = 1'b1;
                     sweep_in    = '0;
                     state_in    = S_CLEAR;
                  end
                  default: begin
                     res_block_in = '0;
                     res_count_in = '0;
                     state_in     = S_OUT;
                  end
               endcase
            end
         end
         S_READ: begin
            mem_raddr = AW'(blk_ff);
            state_in  = S_MOD;
         end
         S_MOD: begin
            mem_waddr    = AW'(blk_ff);
            res_block_in = '0;
            case (mode_ff)
               MODE_INC: begin
                  if (in_total && (rd_data_ff != COUNT_MAX)) begin
                     new_count = rd_data_ff + COUNT_W'(1);
                     mem_we    = 1'b1;
                     mem_wdata = new_count;
                     if (is_data && (rd_data_ff == '0)) begin
                        free_in = free_ff - TOTAL_W'(1);
                     end
                  end
               end
               MODE_DEC: begin
                  if (is_data && (rd_data_ff != '0)) begin
                     new_count = rd_data_ff - COUNT_W'(1);
                     mem_we    = 1'b1;
                     mem_wdata = new_count;
                     if (new_count == '0) begin
                        free_in = free_ff + TOTAL_W'(1);
                        // A freed block lowers the point where the next scan starts.
                        if (blk_ext < hint_ff) begin
                           hint_in = blk_ext;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
            res_count_in = in_total ? new_count : COUNT_MAX;
            state_in     = S_OUT;
         end
         S_SCAN: begin
            // Reads are issued one per cycle; each read is checked the cycle after.
            if (chk_v_ff && (rd_data_ff == '0)) begin
               mem_we       = 1'b1;
               mem_waddr    = chk_addr_ff[AW-1:0];
               mem_wdata    = COUNT_W'(1);
               free_in      = free_ff - TOTAL_W'(1);
               hint_in      = chk_addr_ff + CW'(1);
               res_block_in = chk_addr_ff[BLOCK_W-1:0];
               res_count_in = COUNT_W'(1);
               state_in     = S_OUT;
            end else if (scan_ff < alloc_end) begin
               mem_raddr   = scan_ff[AW-1:0];
               chk_v_in    = 1'b1;
               chk_addr_in = scan_ff;
               scan_in     = scan_ff + CW'(1);
            end else if (!chk_v_ff) begin
               res_block_in = '0;
               res_count_in = '0;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            init_clr_in = 1'b0;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_block_in = res_block_ff;
               rsp_count_in = res_count_ff;
               rsp_free_in  = free_ff;
               rsp_total_in = total_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A new total changes which blocks count as free, so it forces a recount.
      if (csr_wr_en) begin
         dirty_in = 1'b1;
      end
   end

   assign total_in = csr_wr_en ? csr_wr_data : total_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= count_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         init_clr_ff  <= 1'b0;
         chk_v_ff     <= 1'b0;
         hint_ff      <= '0;
         free_ff      <= '0;
         dirty_ff     <= 1'b0;
         total_ff     <= TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         init_clr_ff  <= init_clr_in;
         chk_v_ff     <= chk_v_in;
         hint_ff      <= hint_in;
         free_ff      <= free_in;
         dirty_ff     <= dirty_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      blk_ff       <= blk_in;
      scan_ff      <= scan_in;
      chk_addr_ff  <= chk_addr_in;
      res_block_ff <= res_block_in;
      res_count_ff <= res_count_in;
      rsp_block_ff <= rsp_block_in;
      rsp_count_ff <= rsp_count_in;
      rsp_free_ff  <= rsp_free_in;
      rsp_total_ff <= rsp_total_in;
   end

endmodule

### rtl/core/rcba_checker.sv
`include "assert_macros.svh"

module rcba_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [2:0]                   req_mode,
   input logic [rcba_pkg::BLOCK_W-1:0] req_block_number,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [rcba_pkg::BLOCK_W-1:0] rsp_result_block,
   input logic [rcba_pkg::COUNT_W-1:0] rsp_ref_count,
   input logic [rcba_pkg::TOTAL_W-1:0] rsp_free_count,
   input logic [rcba_pkg::TOTAL_W-1:0] rsp_total_count,
   input logic                         csr_wr_en,
   input logic [rcba_pkg::TOTAL_W-1:0] csr_wr_data
);
   import rcba_pkg::*;

   logic alloc_hit;
   logic unused_ok;

   assign alloc_hit = rsp_valid && (rsp_result_block != '0);
   // These ports carry nothing that the checks below look at.
   assign unused_ok = req_valid ^ req_stall ^ (^req_mode) ^ (^req_block_number)
                      ^ csr_wr_en ^ (^csr_wr_data);

   // No result beat may appear right after reset, while the clearing pass runs.
   `RCBA_ASSERT_ALWAYS(a_no_rsp_after_reset, reset |=> !rsp_valid, "result beat after reset")

   // A block handed out by allocate always carries a count of one.
   `RCBA_ASSERT(a_alloc_count_one, alloc_hit |-> rsp_ref_count == COUNT_W'(1), "allocate count")

   // Free data blocks lie inside the total, so they never outnumber it.
   `RCBA_ASSERT(a_free_le_total, rsp_valid |-> rsp_free_count <= rsp_total_count, "free count")

   // A stalled result beat stays in place.
   `RCBA_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_block), "rsp hold")

endmodule

bind refcount_block_allocator rcba_checker u_rcba_checker (.*);
